>>> rtl/core/bqbp_pkg.sv
`timescale 1ns / 1ps

package bqbp_pkg;

  // Stream and history geometry
  localparam int NUM_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 24;
  localparam int CHAN_BITS    = 1;

  // Coefficient registers, signed Q3.16
  localparam int COEF_BITS    = 20;
  localparam int NUM_REGS     = 6;
  localparam int REG_IDX_BITS = 3;

  // Fixed-point scaling
  localparam int PRE_SHIFT  = SAMPLE_BITS - 16;
  localparam int POST_SHIFT = 32 - PRE_SHIFT;

  // Datapath widths: five products need three guard bits
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int T_BITS    = ACC_BITS - PRE_SHIFT;
  localparam int OPA_BITS  = (T_BITS > SAMPLE_BITS) ? T_BITS : SAMPLE_BITS;
  localparam int MUL_BITS  = OPA_BITS + COEF_BITS;
  localparam int RND_BITS  = MUL_BITS + 1;
  localparam int Y_BITS    = RND_BITS - POST_SHIFT;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(65536);

  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_B0  = 3'd0,
    REG_B1  = 3'd1,
    REG_B2  = 3'd2,
    REG_A1  = 3'd3,
    REG_A2  = 3'd4,
    REG_INV = 3'd5
  } reg_idx_t;

  // Multiplier operand A source
  typedef enum logic [2:0] {
    A_X,
    A_X1,
    A_X2,
    A_Y1,
    A_Y2,
    A_T
  } opa_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JC_NEVER,
    JC_NO_INPUT,
    JC_OUT_BUSY
  } jcond_t;

  // Program steps
  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_MUL_B0 = 4'd1;
  localparam step_t STEP_MUL_B1 = 4'd2;
  localparam step_t STEP_MUL_B2 = 4'd3;
  localparam step_t STEP_MUL_A1 = 4'd4;
  localparam step_t STEP_MUL_A2 = 4'd5;
  localparam step_t STEP_ACC_A2 = 4'd6;
  localparam step_t STEP_SCALE  = 4'd7;
  localparam step_t STEP_OUT    = 4'd8;

  // Datapath control word
  typedef struct packed {
    logic     take_input;
    opa_sel_t a_sel;
    reg_idx_t b_sel;
    logic     mul_en;
    acc_op_t  acc_op;
    logic     commit;
  } ctrl_t;

  // Full microcode word
  typedef struct packed {
    ctrl_t  ctrl;
    jcond_t jcond;
    step_t  jtarget;
    logic   last;
  } ucode_t;

  // Datapath status for jump conditions
  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

endpackage

>>> rtl/core/bqbp_if.sv
`timescale 1ns / 1ps

interface bqbp_in_if;
  import bqbp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [CHAN_BITS-1:0]  channel_in;

  modport source (output valid, output sample_in, output channel_in, input ready);
  modport sink   (input valid, input sample_in, input channel_in, output ready);
endinterface

interface bqbp_out_if;
  import bqbp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CHAN_BITS-1:0]  channel_out;

  modport source (output valid, output sample_out, output channel_out, input ready);
  modport sink   (input valid, input sample_out, input channel_out, output ready);
endinterface

>>> rtl/core/bqbp_coef_regs.sv
`timescale 1ns / 1ps

module bqbp_coef_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bqbp_pkg::REG_IDX_BITS-1:0] cfg_idx,
  input  logic [bqbp_pkg::COEF_BITS-1:0]    cfg_data,
  output bqbp_pkg::coef_t                   coef [bqbp_pkg::NUM_REGS]
);
  import bqbp_pkg::*;

  // Write a coefficient; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if ((i == REG_B0) || (i == REG_INV)) begin
          coef[i] <= COEF_ONE;
        end else begin
          coef[i] <= '0;
        end
      end
    end else if (cfg_we && (cfg_idx < REG_IDX_BITS'(NUM_REGS))) begin
      coef[cfg_idx] <= $signed(cfg_data);
    end
  end

endmodule

>>> rtl/core/bqbp_sequencer.sv
`timescale 1ns / 1ps

module bqbp_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  bqbp_pkg::seq_status_t status,
  output bqbp_pkg::ctrl_t       ctrl
);
  import bqbp_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   take_jump;

  // Program ROM: one control word per step
  function automatic ucode_t rom(input step_t s);
    ucode_t w;
    w = '{ctrl: '{take_input: 1'b0, a_sel: A_X, b_sel: REG_B0, mul_en: 1'b0,
                  acc_op: ACC_HOLD, commit: 1'b0},
          jcond: JC_NEVER, jtarget: STEP_IDLE, last: 1'b0};
    unique case (s)
      STEP_IDLE: begin
        w.ctrl.take_input = 1'b1;
        w.jcond           = JC_NO_INPUT;
        w.jtarget         = STEP_IDLE;
      end
      STEP_MUL_B0: begin
        w.ctrl.a_sel  = A_X;
        w.ctrl.b_sel  = REG_B0;
        w.ctrl.mul_en = 1'b1;
      end
      STEP_MUL_B1: begin
        w.ctrl.a_sel  = A_X1;
        w.ctrl.b_sel  = REG_B1;
        w.ctrl.mul_en = 1'b1;
        w.ctrl.acc_op = ACC_LOAD;
      end
      STEP_MUL_B2: begin
        w.ctrl.a_sel  = A_X2;
        w.ctrl.b_sel  = REG_B2;
        w.ctrl.mul_en = 1'b1;
        w.ctrl.acc_op = ACC_ADD;
      end
      STEP_MUL_A1: begin
        w.ctrl.a_sel  = A_Y1;
        w.ctrl.b_sel  = REG_A1;
        w.ctrl.mul_en = 1'b1;
        w.ctrl.acc_op = ACC_ADD;
      end
      STEP_MUL_A2: begin
        w.ctrl.a_sel  = A_Y2;
        w.ctrl.b_sel  = REG_A2;
        w.ctrl.mul_en = 1'b1;
        w.ctrl.acc_op = ACC_SUB;
      end
      STEP_ACC_A2: begin
        w.ctrl.acc_op = ACC_SUB;
      end
      STEP_SCALE: begin
        w.ctrl.a_sel  = A_T;
        w.ctrl.b_sel  = REG_INV;
        w.ctrl.mul_en = 1'b1;
      end
      STEP_OUT: begin
        w.ctrl.commit = 1'b1;
        w.jcond       = JC_OUT_BUSY;
        w.jtarget     = STEP_OUT;
        w.last        = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  assign word = rom(step);
  assign ctrl = word.ctrl;

  // Evaluate the jump condition and pick the next step
  always_comb begin
    unique case (word.jcond)
      JC_NO_INPUT: take_jump = !status.in_valid;
      JC_OUT_BUSY: take_jump = status.out_busy;
      default:     take_jump = 1'b0;
    endcase
    if (take_jump) begin
      step_next = word.jtarget;
    end else if (word.last) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = step + STEP_BITS'(1);
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/core/bqbp_datapath.sv
`timescale 1ns / 1ps

module bqbp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bqbp_pkg::ctrl_t       ctrl,
  input  bqbp_pkg::coef_t       coef [bqbp_pkg::NUM_REGS],
  output bqbp_pkg::seq_status_t status,
  bqbp_in_if.sink               din,
  bqbp_out_if.source            dout
);
  import bqbp_pkg::*;

  localparam logic signed [ACC_BITS-1:0] PRE_HALF =
    (PRE_SHIFT > 0) ? (ACC_BITS'(1) << (PRE_SHIFT - 1)) : '0;
  localparam logic signed [RND_BITS-1:0] POST_HALF = RND_BITS'(1) << (POST_SHIFT - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Per-channel history
  sample_t hist_x1 [NUM_CHANNELS];
  sample_t hist_x2 [NUM_CHANNELS];
  sample_t hist_y1 [NUM_CHANNELS];
  sample_t hist_y2 [NUM_CHANNELS];

  sample_t                       x_reg;
  logic [CHAN_BITS-1:0]          ch_reg;
  logic signed [MUL_BITS-1:0]    prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    prod_acc;
  logic signed [OPA_BITS-1:0]    opa;
  coef_t                         opb;
  logic signed [RND_BITS-1:0]    rnd;
  logic signed [Y_BITS-1:0]      y_wide;
  logic [Y_BITS-SAMPLE_BITS:0]   y_upper;
  sample_t                       y_sat;
  sample_t                       h_x1, h_x2, h_y1, h_y2;
  logic                          ch_ok;
  logic                          accept;
  logic                          out_busy;
  logic                          commit;

  assign ch_ok    = 32'(ch_reg) < 32'(NUM_CHANNELS);
  assign accept   = din.valid && din.ready;
  assign out_busy = dout.valid && !dout.ready;
  assign commit   = ctrl.commit && !out_busy;

  // Hold off input transactions while in reset
  assign din.ready       = ctrl.take_input && !rst;
  assign status.in_valid = din.valid;
  assign status.out_busy = out_busy;

  // Read the history of the current channel
  assign h_x1 = ch_ok ? hist_x1[ch_reg] : '0;
  assign h_x2 = ch_ok ? hist_x2[ch_reg] : '0;
  assign h_y1 = ch_ok ? hist_y1[ch_reg] : '0;
  assign h_y2 = ch_ok ? hist_y2[ch_reg] : '0;

  // Select multiplier operands
  always_comb begin
    case (ctrl.a_sel)
      A_X:     opa = OPA_BITS'(x_reg);
      A_X1:    opa = OPA_BITS'(h_x1);
      A_X2:    opa = OPA_BITS'(h_x2);
      A_Y1:    opa = OPA_BITS'(h_y1);
      A_Y2:    opa = OPA_BITS'(h_y2);
      A_T:     opa = OPA_BITS'($signed(acc[ACC_BITS-1:PRE_SHIFT]));
      default: opa = '0;
    endcase
  end

  assign opb      = coef[ctrl.b_sel];
  assign prod_acc = $signed(prod[ACC_BITS-1:0]);

  // Round the scaled product to an integer and saturate
  assign rnd     = RND_BITS'(prod) + POST_HALF;
  assign y_wide  = $signed(rnd[RND_BITS-1:POST_SHIFT]);
  assign y_upper = y_wide[Y_BITS-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_upper) || !(|y_upper)) begin
      y_sat = y_wide[SAMPLE_BITS-1:0];
    end else if (y_wide[Y_BITS-1]) begin
      y_sat = SAT_MIN;
    end else begin
      y_sat = SAT_MAX;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg  <= din.sample_in;
      ch_reg <= din.channel_in;
    end
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= opa * opb;
    end
    case (ctrl.acc_op)
      ACC_LOAD: acc <= prod_acc + PRE_HALF;
      ACC_ADD:  acc <= acc + prod_acc;
      ACC_SUB:  acc <= acc - prod_acc;
      default:  acc <= acc;
    endcase
  end

  // Shift the history of the channel on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hist_x1[i] <= '0;
        hist_x2[i] <= '0;
        hist_y1[i] <= '0;
        hist_y2[i] <= '0;
      end
    end else if (commit && ch_ok) begin
      hist_x2[ch_reg] <= hist_x1[ch_reg];
      hist_x1[ch_reg] <= x_reg;
      hist_y2[ch_reg] <= hist_y1[ch_reg];
      hist_y1[ch_reg] <= y_sat;
    end
  end

  // Output register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (commit) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      dout.sample_out  <= ch_ok ? y_sat : '0;
      dout.channel_out <= ch_reg;
    end
  end

endmodule

>>> rtl/core/biquad_bandpass_filter.sv
`timescale 1ns / 1ps
// A sample taken in the idle step runs the 9-step program: five multiply-accumulates
// and one scaling multiply on a single shared multiplier, then the output step, which
// waits while the output is busy, then commits the result to the output register.
// The next sample is taken while a finished result waits in the output register.
// Reset (rst, synchronous): clears all channel history, sets b0 and 1/a0 to 1.0 and
// the other coefficients to zero, and returns the sequencer to its idle step.

module biquad_bandpass_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bqbp_pkg::REG_IDX_BITS-1:0] cfg_idx,
  input  logic [bqbp_pkg::COEF_BITS-1:0]    cfg_data,
  bqbp_in_if.sink                           din,
  bqbp_out_if.source                        dout
);
  import bqbp_pkg::*;

  coef_t       coef [NUM_REGS];
  ctrl_t       ctrl;
  seq_status_t status;

  bqbp_coef_regs u_coef_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .coef     (coef)
  );

  bqbp_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  bqbp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (coef),
    .status (status),
    .din    (din),
    .dout   (dout)
  );

endmodule
